// ===== rtl/core/rsfds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sort and delay split package
// Shared field widths, delay constants and the transaction types of the
// range sort and delay FIFO split block.
// ----------------------------------------------------------------------------
package rsfds_pkg;

   localparam int RANGE_W   = 32;
   localparam int FRAC_W    = 8;
   localparam int GAP_W     = RANGE_W - FRAC_W;
   localparam int BASE_W    = 25;
   localparam int SLOT_W    = 12;
   localparam int USED_W    = 3;
   localparam int OUT_SLOTS = 7;
   localparam int GAP_COUNT = 3;

   // The segment length is a power of two.
   localparam int SLOT_MAX_DELAY = 2048;
   localparam int SLOT_COUNT     = 7;
   localparam int SLOT_SHIFT     = $clog2(SLOT_MAX_DELAY);
   localparam int FULL_W         = GAP_W - SLOT_SHIFT;
   localparam int NEED_W         = FULL_W + 1;
   localparam int SUM_W          = $clog2(2 * SLOT_COUNT + 2);

   localparam logic [SLOT_W-1:0] UNUSED_SLOT = SLOT_W'(3);
   localparam logic [SLOT_W-1:0] FULL_SLOT   = SLOT_W'(SLOT_MAX_DELAY);

   localparam longint unsigned LIGHT_SPEED  = 64'd299792458;
   localparam longint unsigned CLOCK_HZ     = 64'd300000000;
   localparam longint unsigned CLOCK_EXCESS = CLOCK_HZ - LIGHT_SPEED;
   localparam int RECIP_SHIFT = 32;
   localparam longint unsigned RECIP = (CLOCK_EXCESS << RECIP_SHIFT) / LIGHT_SPEED;

   localparam int EXCESS_W = 18;
   localparam int RECIP_W  = 22;
   localparam int QUOT_W   = 22;
   localparam int LIGHT_W  = 29;
   localparam int XPROD_W  = RANGE_W + EXCESS_W;
   localparam int RPROD_W  = RANGE_W + RECIP_W;
   localparam int QPROD_W  = QUOT_W + LIGHT_W;

   typedef struct packed {
      logic [RANGE_W-1:0] range_a;
      logic [RANGE_W-1:0] range_b;
      logic [RANGE_W-1:0] range_c;
      logic [RANGE_W-1:0] range_d;
   } req_type;

   typedef struct packed {
      logic [BASE_W-1:0] base_delay;
      logic [SLOT_W-1:0] slot_delay_0;
      logic [SLOT_W-1:0] slot_delay_1;
      logic [SLOT_W-1:0] slot_delay_2;
      logic [SLOT_W-1:0] slot_delay_3;
      logic [SLOT_W-1:0] slot_delay_4;
      logic [SLOT_W-1:0] slot_delay_5;
      logic [SLOT_W-1:0] slot_delay_6;
      logic [USED_W-1:0] used_after_gap_0;
      logic [USED_W-1:0] used_after_gap_1;
      logic [USED_W-1:0] used_after_gap_2;
      logic              slot_overflow;
   } rsp_type;

endpackage

// ===== rtl/core/range_sort_fifo_delay_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sort and delay FIFO split
// Sorts four scatterer ranges and derives the base delay, the delay FIFO
// slot settings and the cumulative slot counts.
//
// A request transaction carries four ranges in 1/256 metre units on req_data
// and is taken when req_valid and req_ready are high at a clock edge. Each
// request yields exactly one response transaction on rsp_data, handed over
// when rsp_valid and rsp_ready are high. The pipeline has six register
// stages: three for the sorting network, then the products and gap split,
// the quotient estimate and slot positions, and the correction and slot
// fill that load the output register. One request is taken every cycle
// while no stage stalls. The conversion multipliers and the sorting network
// set the stage depth. Each stage holds its transaction while the next stage
// is occupied and stalled, so an empty stage still takes new data when the
// receiver stalls, and nothing is lost or repeated. A synchronous reset
// empties all stages; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module range_sort_fifo_delay_split (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rsfds_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsfds_pkg::rsp_type rsp_data
);
   import rsfds_pkg::*;

   logic [6:1] vld_ff;
   logic [7:1] en;

   logic [RANGE_W-1:0] s1_ff [4];
   logic [RANGE_W-1:0] s1_in [4];
   logic [RANGE_W-1:0] s2_ff [4];
   logic [RANGE_W-1:0] s2_in [4];
   logic [RANGE_W-1:0] s3_ff [4];
   logic [RANGE_W-1:0] s3_in [4];

   logic [RANGE_W-1:0] r0_s4_ff;
   logic [XPROD_W-1:0] xprod_s4_ff;
   logic [XPROD_W-1:0] xprod_s4_in;
   logic [RPROD_W-1:0] rprod_s4_ff;
   logic [RPROD_W-1:0] rprod_s4_in;
   logic [SUM_W-1:0]      full_s4_ff [GAP_COUNT];
   logic [SUM_W-1:0]      full_s4_in [GAP_COUNT];
   logic [SUM_W-1:0]      need_s4_ff [GAP_COUNT];
   logic [SUM_W-1:0]      need_s4_in [GAP_COUNT];
   logic [SLOT_SHIFT-1:0] rem_s4_ff  [GAP_COUNT];
   logic [SLOT_SHIFT-1:0] rem_s4_in  [GAP_COUNT];

   logic [RANGE_W-1:0] r0_s5_ff;
   logic [XPROD_W-1:0] xprod_s5_ff;
   logic [QUOT_W-1:0]  quot_s5_ff;
   logic [QUOT_W-1:0]  quot_s5_in;
   logic [QPROD_W-1:0] qprod_s5_ff;
   logic [QPROD_W-1:0] qprod_s5_in;
   logic [SUM_W-1:0]      full_s5_ff  [GAP_COUNT];
   logic [SUM_W-1:0]      start_s5_ff [GAP_COUNT];
   logic [SUM_W-1:0]      start_s5_in [GAP_COUNT];
   logic [SUM_W-1:0]      end_s5_ff   [GAP_COUNT];
   logic [SUM_W-1:0]      end_s5_in   [GAP_COUNT];
   logic [SLOT_SHIFT-1:0] rem_s5_ff   [GAP_COUNT];
   logic                  over_s5_ff;
   logic                  over_s5_in;

   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_comb begin
      en[7] = rsp_ready;
      for (int k = 6; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[1];
   assign rsp_valid = vld_ff[6];
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[1]) begin
            vld_ff[1] <= req_valid;
         end
         for (int k = 2; k <= 6; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Stage 1: sort the pairs (a, b) and (c, d).
   always_comb begin
      s1_in[0] = (req_data.range_b < req_data.range_a) ? req_data.range_b : req_data.range_a;
      s1_in[1] = (req_data.range_b < req_data.range_a) ? req_data.range_a : req_data.range_b;
      s1_in[2] = (req_data.range_d < req_data.range_c) ? req_data.range_d : req_data.range_c;
      s1_in[3] = (req_data.range_d < req_data.range_c) ? req_data.range_c : req_data.range_d;
   end

   // Stage 2: merge the minima and the maxima.
   always_comb begin
      s2_in[0] = (s1_ff[2] < s1_ff[0]) ? s1_ff[2] : s1_ff[0];
      s2_in[2] = (s1_ff[2] < s1_ff[0]) ? s1_ff[0] : s1_ff[2];
      s2_in[1] = (s1_ff[3] < s1_ff[1]) ? s1_ff[3] : s1_ff[1];
      s2_in[3] = (s1_ff[3] < s1_ff[1]) ? s1_ff[1] : s1_ff[3];
   end

   // Stage 3: order the two middle values.
   always_comb begin
      s3_in[0] = s2_ff[0];
      s3_in[1] = (s2_ff[2] < s2_ff[1]) ? s2_ff[2] : s2_ff[1];
      s3_in[2] = (s2_ff[2] < s2_ff[1]) ? s2_ff[1] : s2_ff[2];
      s3_in[3] = s2_ff[3];
   end

   // Stage 4: conversion products and the split of each gap into segments.
   always_comb begin
      logic [RANGE_W-1:0] diff;
      logic [GAP_W-1:0]   gap;
      logic [FULL_W-1:0]  full;
      logic [NEED_W-1:0]  need;
      xprod_s4_in = XPROD_W'(s3_ff[0]) * XPROD_W'(CLOCK_EXCESS);
      rprod_s4_in = RPROD_W'(s3_ff[0]) * RPROD_W'(RECIP);
      for (int g = 0; g < GAP_COUNT; g++) begin
         diff = s3_ff[g+1] - s3_ff[g];
         gap  = diff[RANGE_W-1:FRAC_W];
         full = gap[GAP_W-1:SLOT_SHIFT];
         rem_s4_in[g] = gap[SLOT_SHIFT-1:0];
         need = NEED_W'(full) + NEED_W'(rem_s4_in[g] != '0);
         full_s4_in[g] = (full > FULL_W'(SLOT_COUNT + 1)) ? SUM_W'(SLOT_COUNT + 1)
                                                          : SUM_W'(full);
         need_s4_in[g] = (need > NEED_W'(SLOT_COUNT + 1)) ? SUM_W'(SLOT_COUNT + 1)
                                                          : SUM_W'(need);
      end
   end

   // Stage 5: quotient estimate times the light speed, and slot positions.
   always_comb begin
      logic [SUM_W-1:0] pos;
      logic [SUM_W-1:0] sum;
      quot_s5_in  = rprod_s4_ff[RECIP_SHIFT +: QUOT_W];
      qprod_s5_in = QPROD_W'(quot_s5_in) * QPROD_W'(LIGHT_SPEED);
      pos = '0;
      over_s5_in = 1'b0;
      for (int g = 0; g < GAP_COUNT; g++) begin
         start_s5_in[g] = pos;
         sum = pos + need_s4_ff[g];
         end_s5_in[g] = sum;
         if (sum > SUM_W'(SLOT_COUNT)) begin
            pos = SUM_W'(SLOT_COUNT);
            over_s5_in = 1'b1;
         end else begin
            pos = sum;
         end
      end
   end

   // Stage 6: quotient correction, base delay and slot fill.
   always_comb begin
      logic [QPROD_W-1:0]     rem_div;
      logic [QUOT_W-1:0]      quot;
      logic [RANGE_W:0]       total;
      logic [SLOT_W-1:0]      slot [OUT_SLOTS];
      logic [SUM_W-1:0]       used [GAP_COUNT];
      logic [SUM_W-1:0]       idx;
      rem_div = QPROD_W'(xprod_s5_ff) - qprod_s5_ff;
      quot = quot_s5_ff + QUOT_W'(rem_div >= QPROD_W'(LIGHT_SPEED));
      total = (RANGE_W + 1)'(r0_s5_ff) + (RANGE_W + 1)'(quot);
      for (int s = 0; s < OUT_SLOTS; s++) begin
         slot[s] = UNUSED_SLOT;
         idx = SUM_W'(s);
         for (int g = 0; g < GAP_COUNT; g++) begin
            if (s < SLOT_COUNT && idx >= start_s5_ff[g] && idx < end_s5_ff[g]) begin
               slot[s] = ((idx - start_s5_ff[g]) < full_s5_ff[g]) ? FULL_SLOT
                                                                 : SLOT_W'(rem_s5_ff[g]);
            end
         end
      end
      for (int g = 0; g < GAP_COUNT - 1; g++) begin
         used[g] = start_s5_ff[g+1];
      end
      used[GAP_COUNT-1] = (end_s5_ff[GAP_COUNT-1] > SUM_W'(SLOT_COUNT)) ? SUM_W'(SLOT_COUNT)
                                                                        : end_s5_ff[GAP_COUNT-1];
      rsp_data_in.base_delay       = BASE_W'(total >> FRAC_W);
      rsp_data_in.slot_delay_0     = slot[0];
      rsp_data_in.slot_delay_1     = slot[1];
      rsp_data_in.slot_delay_2     = slot[2];
      rsp_data_in.slot_delay_3     = slot[3];
      rsp_data_in.slot_delay_4     = slot[4];
      rsp_data_in.slot_delay_5     = slot[5];
      rsp_data_in.slot_delay_6     = slot[6];
      rsp_data_in.used_after_gap_0 = USED_W'(used[0]);
      rsp_data_in.used_after_gap_1 = USED_W'(used[1]);
      rsp_data_in.used_after_gap_2 = USED_W'(used[2]);
      rsp_data_in.slot_overflow    = over_s5_ff;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_ff <= s1_in;
      end
      if (en[2]) begin
         s2_ff <= s2_in;
      end
      if (en[3]) begin
         s3_ff <= s3_in;
      end
      if (en[4]) begin
         r0_s4_ff    <= s3_ff[0];
         xprod_s4_ff <= xprod_s4_in;
         rprod_s4_ff <= rprod_s4_in;
         full_s4_ff  <= full_s4_in;
         need_s4_ff  <= need_s4_in;
         rem_s4_ff   <= rem_s4_in;
      end
      if (en[5]) begin
         r0_s5_ff    <= r0_s4_ff;
         xprod_s5_ff <= xprod_s4_ff;
         quot_s5_ff  <= quot_s5_in;
         qprod_s5_ff <= qprod_s5_in;
         full_s5_ff  <= full_s4_ff;
         start_s5_ff <= start_s5_in;
         end_s5_ff   <= end_s5_in;
         rem_s5_ff   <= rem_s4_ff;
         over_s5_ff  <= over_s5_in;
      end
      if (en[6]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
